// File: rtl/core/pipeline_flow_tracker_macros.svh
// assertion macros shared by the pipeline flow tracker rtl
`ifndef PIPELINE_FLOW_TRACKER_MACROS_SVH
`define PIPELINE_FLOW_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pipeline_flow_tracker assertion failed");

// next-cycle implication, checked out of reset
`define PFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pipeline_flow_tracker assertion failed");

`else

`define PFT_ASSERT_NOW(label, ante, cons)
`define PFT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/pft_pkg.sv
// types, constants and helpers for the pipeline flow tracker
`timescale 1ns / 1ps
`default_nettype none

package pft_pkg;

    localparam int unsigned NUM_STAGES = 5;
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 80;

    // stage indexes
    localparam int unsigned ST_IF  = 0;
    localparam int unsigned ST_ID  = 1;
    localparam int unsigned ST_EX  = 2;
    localparam int unsigned ST_MEM = 3;
    localparam int unsigned ST_WB  = 4;

    // opcode codes
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [1:0] QUAD_C1    = 2'b01;
    localparam logic [1:0] QUAD_FULL  = 2'b11;
    localparam logic [2:0] F3_RSV_A   = 3'd2;
    localparam logic [2:0] F3_RSV_B   = 3'd3;
    localparam logic [2:0] CF3_JAL    = 3'd1;
    localparam logic [2:0] CF3_J      = 3'd5;
    localparam logic [2:0] CF3_BEQZ   = 3'd6;
    localparam logic [2:0] CF3_BNEZ   = 3'd7;

    // one pipe stage
    typedef struct packed {
        logic        valid;
        logic [31:0] pc;
        logic [31:0] word;
        logic        predicted;
        logic [31:0] target;
    } t_slot;

    // per-cell control group
    typedef struct packed {
        logic kill;
        logic mark;
        logic clr;
    } t_cell_ctl;

    // registered part of one result beat
    typedef struct packed {
        logic        committed;
        logic        redirected;
        logic        mispredicted;
        logic [2:0]  flushed;
        logic        fetch_issued;
        logic [31:0] fetch_address;
    } t_result;

    // instruction length from the low two bits
    function automatic logic [31:0] f_word_len(input logic [1:0] lo);
        return (lo == QUAD_FULL) ? 32'd4 : 32'd2;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pft_stage_cell.sv
// one pipe stage cell: holds a slot and takes its neighbor's slot each beat
`timescale 1ns / 1ps
`default_nettype none

module pft_stage_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_adv,
    input  pft_pkg::t_cell_ctl i_ctl,
    input  wire [31:0]        i_target,
    input  pft_pkg::t_slot    i_d,
    output pft_pkg::t_slot    o_q
);
    import pft_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // next slot: shift in, drop on kill, tag a prediction on mark, clear on clr when held
    always_comb begin
        n_slot = r_slot;
        if (i_adv) begin
            if (i_ctl.kill) begin
                n_slot.valid     = 1'b0;
                n_slot.predicted = 1'b0;
            end else begin
                n_slot = i_d;
                if (i_ctl.mark) begin
                    n_slot.predicted = 1'b1;
                    n_slot.target    = i_target;
                end
            end
        end else if (i_ctl.clr) begin
            n_slot.valid     = 1'b0;
            n_slot.predicted = 1'b0;
        end
    end

    // slot register, control bits reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid     <= 1'b0;
            r_slot.predicted <= 1'b0;
            r_slot.pc        <= n_slot.pc;
            r_slot.word      <= n_slot.word;
            r_slot.target    <= n_slot.target;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_q = r_slot;

endmodule

`default_nettype wire

// File: rtl/core/pft_branch_decode.sv
// static target decode for branches, jal and compressed jumps and branches
`timescale 1ns / 1ps
`default_nettype none

module pft_branch_decode (
    input  wire [31:0] i_word,
    input  wire [31:0] i_pc,
    output logic       o_hit,
    output logic [31:0] o_target
);
    import pft_pkg::*;

    logic [31:0] w_imm;
    logic [2:0]  w_f3;
    logic [2:0]  w_cf3;

    assign w_f3  = i_word[14:12];
    assign w_cf3 = i_word[15:13];

    // immediate select by encoding
    always_comb begin
        o_hit = 1'b0;
        w_imm = '0;
        if (i_word[1:0] == QUAD_FULL) begin
            if (i_word[6:0] == OPC_BRANCH && w_f3 != F3_RSV_A && w_f3 != F3_RSV_B) begin
                o_hit = 1'b1;
                w_imm = {{20{i_word[31]}}, i_word[7], i_word[30:25], i_word[11:8], 1'b0};
            end else if (i_word[6:0] == OPC_JAL) begin
                o_hit = 1'b1;
                w_imm = {{12{i_word[31]}}, i_word[19:12], i_word[20], i_word[30:21], 1'b0};
            end
        end else if (i_word[1:0] == QUAD_C1) begin
            if (w_cf3 inside {CF3_JAL, CF3_J}) begin
                o_hit = 1'b1;
                w_imm = {{21{i_word[12]}}, i_word[8], i_word[10:9], i_word[6], i_word[7],
                         i_word[2], i_word[11], i_word[5:3], 1'b0};
            end else if (w_cf3 inside {CF3_BEQZ, CF3_BNEZ}) begin
                o_hit = 1'b1;
                w_imm = {{24{i_word[12]}}, i_word[6:5], i_word[2], i_word[11:10],
                         i_word[4:3], 1'b0};
            end
        end
    end

    // pc-relative target
    assign o_target = i_pc + w_imm;

endmodule

`default_nettype wire

// File: rtl/core/pipeline_flow_tracker.sv
// top level of the five-stage pipeline flow tracker
// Tracks the IF, ID, EX, MEM and WB stages of an RV32IC core, one input beat
// per core clock while s_axis_tready is high. Input beat (s_axis): fetch word,
// retire and fetch enables and the core's next pc for the instruction entering
// write-back. Result beat (m_axis): commit, redirect, mispredict and flush status,
// the fetch issued this clock, the write-back pc and the stage valid bits.
// Configuration: i_cfg_we with i_cfg_wdata loads reset_pc, which becomes the fetch
// address and cancels a pending fetch if no beat is accepted; write it only while idle.
// The result of a beat is registered and valid on m_axis the cycle after accept.
// Throughput: one beat per cycle while s_axis_tready is high; the stage cells shift
// once per accepted beat and the retire compare and EX target add settle within that cycle.
// Reset (synchronous, i_rst_n low): all stages empty, fetch address 0, no
// fetch pending, no result held; no clearing pass is needed.
// Stall: the result sits in an output register; s_axis_tready stays high
// while that register is empty or being taken, so a stalled receiver holds
// the tracker after at most one further beat.
`timescale 1ns / 1ps
`default_nettype none

`include "pipeline_flow_tracker_macros.svh"

module pipeline_flow_tracker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // reset_pc write port
    input  wire        i_cfg_we,
    input  wire [31:0] i_cfg_wdata,
    // input beats
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    // fetch_word[31:0], may_retire[32], may_fetch[33], next_pc[65:34], zero[71:66]
    input  wire [pft_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // result beats
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    // committed[0], redirected[1], mispredicted[2], flushed[5:3], fetch_issued[6],
    // fetch_address[38:7], retired_pc[70:39], stage_occupancy[75:71], zero[79:76]
    output logic [pft_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pft_pkg::*;

    // input fields
    logic [31:0] w_fetch_word;
    logic        w_may_retire;
    logic        w_may_fetch;
    logic [31:0] w_next_pc;
    logic        w_accept;

    assign w_fetch_word = s_axis_tdata[31:0];
    assign w_may_retire = s_axis_tdata[32];
    assign w_may_fetch  = s_axis_tdata[33];
    assign w_next_pc    = s_axis_tdata[65:34];

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_res;
    t_result n_res;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // cell chain wiring
    t_slot     w_q   [NUM_STAGES];
    t_slot     w_d   [NUM_STAGES];
    t_cell_ctl w_ctl [NUM_STAGES];

    logic [31:0] r_front_pc;
    logic [31:0] n_front_pc;
    logic [31:0] w_front_base;

    logic        w_bd_hit;
    logic [31:0] w_bd_target;
    logic        w_retire;
    logic [31:0] w_seq_pc;
    logic [31:0] w_expect_pc;
    logic        w_flush;
    logic        w_predict;
    logic [2:0]  w_flush_cnt;

    // target decode on the slot about to enter EX
    pft_branch_decode u_decode (
        .i_word   (w_q[ST_ID].word),
        .i_pc     (w_q[ST_ID].pc),
        .o_hit    (w_bd_hit),
        .o_target (w_bd_target)
    );

    // retire check on the slot about to enter WB
    assign w_retire    = w_q[ST_MEM].valid && w_may_retire;
    assign w_seq_pc    = w_q[ST_MEM].pc + f_word_len(w_q[ST_MEM].word[1:0]);
    assign w_expect_pc = w_q[ST_MEM].predicted ? w_q[ST_MEM].target : w_seq_pc;
    assign w_flush     = w_retire && (w_next_pc != w_expect_pc);
    assign w_predict   = !w_flush && w_q[ST_ID].valid && !w_q[ST_ID].predicted && w_bd_hit;

    // discarded valid stages
    always_comb begin
        w_flush_cnt = 3'd0;
        if (w_flush) begin
            w_flush_cnt = {2'b00, w_q[ST_IF].valid} + {2'b00, w_q[ST_ID].valid}
                        + {2'b00, w_q[ST_EX].valid};
        end else if (w_predict) begin
            w_flush_cnt = {2'b00, w_q[ST_IF].valid};
        end
    end

    // front end address
    assign w_front_base = w_q[ST_IF].valid ? r_front_pc + f_word_len(w_fetch_word[1:0])
                                           : r_front_pc;
    always_comb begin
        n_front_pc = r_front_pc;
        if (w_accept) begin
            if (w_predict) begin
                n_front_pc = w_bd_target;
            end else if (w_flush) begin
                n_front_pc = w_next_pc;
            end else begin
                n_front_pc = w_front_base;
            end
        end else if (i_cfg_we) begin
            n_front_pc = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_pc <= '0;
        end else begin
            r_front_pc <= n_front_pc;
        end
    end

    // cell inputs and control
    always_comb begin
        w_d[ST_IF]           = '0;
        w_d[ST_IF].valid     = w_may_fetch;
        w_d[ST_IF].pc        = n_front_pc;
        w_d[ST_ID]           = w_q[ST_IF];
        w_d[ST_ID].word      = w_fetch_word;
        w_d[ST_EX]           = w_q[ST_ID];
        w_d[ST_MEM]          = w_q[ST_EX];
        w_d[ST_WB]           = w_q[ST_MEM];
        for (int i = 0; i < NUM_STAGES; i++) begin
            w_ctl[i] = '0;
        end
        w_ctl[ST_IF].clr   = i_cfg_we;
        w_ctl[ST_ID].kill  = w_flush || w_predict;
        w_ctl[ST_EX].kill  = w_flush;
        w_ctl[ST_EX].mark  = w_predict;
        w_ctl[ST_MEM].kill = w_flush;
    end

    // row of stage cells
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        pft_stage_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_accept),
            .i_ctl    (w_ctl[g]),
            .i_target (w_bd_target),
            .i_d      (w_d[g]),
            .o_q      (w_q[g])
        );
    end

    // result register
    always_comb begin
        n_res               = r_res;
        n_out_valid         = r_out_valid && !m_axis_tready;
        if (w_accept) begin
            n_out_valid         = 1'b1;
            n_res.committed     = w_retire;
            n_res.redirected    = w_retire && (w_next_pc != w_seq_pc);
            n_res.mispredicted  = w_flush && w_q[ST_MEM].predicted;
            n_res.flushed       = w_flush_cnt;
            n_res.fetch_issued  = w_may_fetch;
            n_res.fetch_address = n_front_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_res <= n_res;
    end

    // result beat: stage state is read straight from the cells
    logic [4:0]  w_occ;
    logic [31:0] w_retired_pc;

    assign w_occ = {w_q[ST_WB].valid, w_q[ST_MEM].valid, w_q[ST_EX].valid,
                    w_q[ST_ID].valid, w_q[ST_IF].valid};
    assign w_retired_pc = w_q[ST_WB].valid ? w_q[ST_WB].pc : 32'd0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, w_occ, w_retired_pc, r_res.fetch_address,
                            r_res.fetch_issued, r_res.flushed, r_res.mispredicted,
                            r_res.redirected, r_res.committed};

    // checks
    `PFT_ASSERT_NOW(a_flush_or_predict, w_accept, !(w_flush && w_predict))
    `PFT_ASSERT_NEXT(a_result_after_accept, w_accept, r_out_valid)
    `PFT_ASSERT_NEXT(a_flush_empties, w_accept && w_flush, !w_q[ST_ID].valid && !w_q[ST_EX].valid && !w_q[ST_MEM].valid)
    `PFT_ASSERT_NEXT(a_predict_marks_ex, w_accept && w_predict, w_q[ST_EX].valid && w_q[ST_EX].predicted && !w_q[ST_ID].valid)

endmodule

`default_nettype wire
